/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* rtl/gbhs_pkg.sv */
package gbhs_pkg;

  localparam int unsigned HeightBits      = 24;
  localparam int unsigned CoordBits       = 32;
  localparam int unsigned CellSizeBits    = 24;
  localparam int unsigned DimBits         = 9;
  localparam int unsigned MaxColumns      = 256;
  localparam int unsigned MaxRows         = 256;
  localparam int unsigned ColBits         = $clog2(MaxColumns);
  localparam int unsigned RowBits         = $clog2(MaxRows);
  localparam int unsigned IndexBits       = 16;
  localparam int unsigned GridDepth       = 1 << IndexBits;
  localparam int unsigned FracBits        = 16;
  localparam int unsigned WeightBits      = FracBits + 1;
  localparam int unsigned QuotBits        = CoordBits + FracBits;
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages       = QuotBits / DivStepsPerStage;
  localparam int unsigned Latency         = DivStages + 8;
  localparam int unsigned CfgIndexBits    = 3;
  localparam int unsigned CfgDataBits     = 32;
  localparam int unsigned ProdBits        = HeightBits + WeightBits + 1;
  localparam int unsigned SumBits         = ProdBits + 1;
  localparam int unsigned MulBits         = SumBits + WeightBits + 1;
  localparam int unsigned NumBits         = MulBits + 1;
  localparam int unsigned RoundShift      = 2 * FracBits;

  localparam logic [HeightBits-1:0] NoDataReset = {1'b1, {(HeightBits-1){1'b0}}};

  typedef enum logic [CfgIndexBits-1:0] {
    CfgOriginEast  = 3'd0,
    CfgOriginNorth = 3'd1,
    CfgCellSize    = 3'd2,
    CfgGridColumns = 3'd3,
    CfgGridRows    = 3'd4,
    CfgNoData      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                  valid;
    logic                  action;
    logic [IndexBits-1:0]  idx;
    logic [HeightBits-1:0] hgt;
    logic                  fail;
  } item_t;

  typedef struct packed {
    logic [CellSizeBits-1:0] rem;
    logic [QuotBits-1:0]     num;
  } div_t;

endpackage

/* rtl/gbhs_ram.sv */
module gbhs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gbhs_div_stage.sv */
module gbhs_div_stage import gbhs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CellSizeBits-1:0] divisor_i,
  input  item_t                   item_i,
  input  div_t                    east_i,
  input  div_t                    north_i,
  output item_t                   item_o,
  output div_t                    east_o,
  output div_t                    north_o
);

  // restoring division, four quotient bits per stage
  function automatic div_t div_steps(div_t a, logic [CellSizeBits-1:0] dv);
    div_t                  r;
    logic [CellSizeBits:0] t;
    r = a;
    for (int i = 0; i < DivStepsPerStage; i++) begin
      t = {r.rem, r.num[QuotBits-1]};
      if (t >= {1'b0, dv}) begin
        t     = t - {1'b0, dv};
        r.num = {r.num[QuotBits-2:0], 1'b1};
      end else begin
        r.num = {r.num[QuotBits-2:0], 1'b0};
      end
      r.rem = t[CellSizeBits-1:0];
    end
    return r;
  endfunction

  item_t item_q;
  div_t  east_q, north_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    east_q  <= div_steps(east_i, divisor_i);
    north_q <= div_steps(north_i, divisor_i);
  end

  assign item_o  = item_q;
  assign east_o  = east_q;
  assign north_o = north_q;

endmodule

/* rtl/gbhs_blend.sv */
module gbhs_blend import gbhs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  item_t                 item_i,
  input  logic [FracBits-1:0]   tx_i,
  input  logic [FracBits-1:0]   ty_i,
  input  logic [HeightBits-1:0] no_data_i,
  input  logic [HeightBits-1:0] h00_i,
  input  logic [HeightBits-1:0] h10_i,
  input  logic [HeightBits-1:0] h01_i,
  input  logic [HeightBits-1:0] h11_i,
  output logic                  result_valid_o,
  output logic                  found_o,
  output logic [HeightBits-1:0] height_o
);

  logic [WeightBits-1:0] wx0, wy0_d;
  logic                  nodata;

  logic                       v1_q, f1_q, v2_q, f2_q, v3_q, f3_q;
  logic signed [ProdBits-1:0] p00_q, p10_q, p01_q, p11_q;
  logic [WeightBits-1:0]      wy0_q, wy1_q, wy0_2_q, wy1_2_q;
  logic signed [SumBits-1:0]  r0_q, r1_q;
  logic signed [MulBits-1:0]  m0_q, m1_q;
  logic signed [NumBits-1:0]  num;

  logic                  res_valid_q, found_q;
  logic [HeightBits-1:0] height_q;

  assign wx0   = WeightBits'(32'd1 << FracBits) - WeightBits'(tx_i);
  assign wy0_d = WeightBits'(32'd1 << FracBits) - WeightBits'(ty_i);
  assign nodata = (h00_i == no_data_i) || (h10_i == no_data_i) ||
                  (h01_i == no_data_i) || (h11_i == no_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      v1_q        <= item_i.valid && item_i.action;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      res_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q    <= item_i.fail || nodata;
    p00_q   <= $signed(h00_i) * $signed({1'b0, wx0});
    p10_q   <= $signed(h10_i) * $signed({1'b0, WeightBits'(tx_i)});
    p01_q   <= $signed(h01_i) * $signed({1'b0, wx0});
    p11_q   <= $signed(h11_i) * $signed({1'b0, WeightBits'(tx_i)});
    wy0_q   <= wy0_d;
    wy1_q   <= WeightBits'(ty_i);
    f2_q    <= f1_q;
    r0_q    <= SumBits'(p00_q) + SumBits'(p10_q);
    r1_q    <= SumBits'(p01_q) + SumBits'(p11_q);
    wy0_2_q <= wy0_q;
    wy1_2_q <= wy1_q;
    f3_q    <= f2_q;
    m0_q    <= r0_q * $signed({1'b0, wy0_2_q});
    m1_q    <= r1_q * $signed({1'b0, wy1_2_q});
    found_q  <= !f3_q;
    height_q <= f3_q ? '0 : num[RoundShift +: HeightBits];
  end

  // round to nearest, ties upward, then drop the fraction
  assign num = NumBits'(m0_q) + NumBits'(m1_q) + NumBits'(64'd1 << (RoundShift - 1));

  assign result_valid_o = res_valid_q;
  assign found_o        = found_q;
  assign height_o       = height_q;

endmodule

/* rtl/grid_bilinear_height_sampler_top.sv */
// channel  | handshake                | payload
// command  | start, busy              | action_i, cell_index_i, cell_height_i, easting_i, northing_i
// result   | result_valid_o strobe    | found_o, height_o
// config   | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle; a sample's result comes out once it has passed through
// twelve divider stages of four quotient bits, plus entry, locate, address, grid read
// and four blend stages
// loads take the same path and write the grid where samples read it, keeping order
// reset clears valid bits and sets configuration registers; grid contents undefined until loaded
// busy stays low and nothing stalls; results cannot be held off
`include "assert_macros.svh"
module grid_bilinear_height_sampler_top import gbhs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    action_i,
  input  logic [IndexBits-1:0]    cell_index_i,
  input  logic [HeightBits-1:0]   cell_height_i,
  input  logic [CoordBits-1:0]    easting_i,
  input  logic [CoordBits-1:0]    northing_i,
  output logic                    result_valid_o,
  output logic                    found_o,
  output logic [HeightBits-1:0]   height_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  logic [CoordBits-1:0]    origin_east_q, origin_north_q;
  logic [CellSizeBits-1:0] cell_size_q;
  logic [DimBits-1:0]      grid_columns_q, grid_rows_q;
  logic [HeightBits-1:0]   no_data_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_east_q  <= '0;
      origin_north_q <= '0;
      cell_size_q    <= '0;
      grid_columns_q <= '0;
      grid_rows_q    <= '0;
      no_data_q      <= NoDataReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgOriginEast:  origin_east_q  <= cfg_data_i[CoordBits-1:0];
        CfgOriginNorth: origin_north_q <= cfg_data_i[CoordBits-1:0];
        CfgCellSize:    cell_size_q    <= cfg_data_i[CellSizeBits-1:0];
        CfgGridColumns: grid_columns_q <= cfg_data_i[DimBits-1:0];
        CfgGridRows:    grid_rows_q    <= cfg_data_i[DimBits-1:0];
        CfgNoData:      no_data_q      <= cfg_data_i[HeightBits-1:0];
        default: ;
      endcase
    end
  end

  logic [DimBits-1:0] cols_eff, rows_eff, cols_m1, rows_m1;
  logic               bad_tile;

  assign cols_eff = (grid_columns_q > DimBits'(MaxColumns)) ? DimBits'(MaxColumns)
                                                            : grid_columns_q;
  assign rows_eff = (grid_rows_q > DimBits'(MaxRows)) ? DimBits'(MaxRows) : grid_rows_q;
  assign cols_m1  = cols_eff - DimBits'(1);
  assign rows_m1  = rows_eff - DimBits'(1);
  assign bad_tile = (cols_eff == '0) || (rows_eff == '0) || (cell_size_q == '0);

  // entry stage: origin offset, below-origin and bad-tile check
  item_t item0_q;
  div_t  east0_q, north0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item0_q <= '0;
    end else begin
      item0_q.valid  <= start && !busy;
      item0_q.action <= action_i;
      item0_q.idx    <= cell_index_i;
      item0_q.hgt    <= cell_height_i;
      item0_q.fail   <= bad_tile || (easting_i < origin_east_q) ||
                        (northing_i < origin_north_q);
    end
  end

  always_ff @(posedge clk_i) begin
    east0_q.rem  <= '0;
    east0_q.num  <= {easting_i - origin_east_q, FracBits'(0)};
    north0_q.rem <= '0;
    north0_q.num <= {northing_i - origin_north_q, FracBits'(0)};
  end

  item_t item_s  [DivStages+1];
  div_t  east_s  [DivStages+1];
  div_t  north_s [DivStages+1];

  assign item_s[0]  = item0_q;
  assign east_s[0]  = east0_q;
  assign north_s[0] = north0_q;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    gbhs_div_stage u_stage (
      .clk_i,
      .rst_ni,
      .divisor_i (cell_size_q),
      .item_i    (item_s[g]),
      .east_i    (east_s[g]),
      .north_i   (north_s[g]),
      .item_o    (item_s[g+1]),
      .east_o    (east_s[g+1]),
      .north_o   (north_s[g+1])
    );
  end

  // locate stage: range check, neighbour clamp
  logic [CoordBits-1:0] qe, qn;
  logic [FracBits-1:0]  txe, tyn;
  logic                 rnz_e, rnz_n, out_e, out_n;
  logic [ColBits-1:0]   x0_d, x1_d;
  logic [RowBits-1:0]   y0_d, y1_d;
  logic [DimBits-1:0]   x0p1, y0p1;

  assign qe    = east_s[DivStages].num[QuotBits-1:FracBits];
  assign txe   = east_s[DivStages].num[FracBits-1:0];
  assign qn    = north_s[DivStages].num[QuotBits-1:FracBits];
  assign tyn   = north_s[DivStages].num[FracBits-1:0];
  // the exact quotient has a fraction when either remainder part is nonzero
  assign rnz_e = (txe != '0) || (east_s[DivStages].rem != '0);
  assign rnz_n = (tyn != '0) || (north_s[DivStages].rem != '0);
  assign out_e = (qe > CoordBits'(cols_m1)) || ((qe == CoordBits'(cols_m1)) && rnz_e);
  assign out_n = (qn > CoordBits'(rows_m1)) || ((qn == CoordBits'(rows_m1)) && rnz_n);
  assign x0_d  = qe[ColBits-1:0];
  assign y0_d  = qn[RowBits-1:0];
  assign x0p1  = DimBits'(x0_d) + DimBits'(1);
  assign y0p1  = DimBits'(y0_d) + DimBits'(1);
  assign x1_d  = (x0p1 < cols_eff) ? x0p1[ColBits-1:0] : x0_d;
  assign y1_d  = (y0p1 < rows_eff) ? y0p1[RowBits-1:0] : y0_d;

  item_t               item_p_d;
  item_t               item_p_q;
  logic [ColBits-1:0]  x0_p_q, x1_p_q;
  logic [RowBits-1:0]  y0_p_q, y1_p_q;
  logic [FracBits-1:0] tx_p_q, ty_p_q;

  always_comb begin
    item_p_d      = item_s[DivStages];
    item_p_d.fail = item_s[DivStages].fail || out_e || out_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_p_q <= '0;
    end else begin
      item_p_q <= item_p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_p_q <= x0_d;
    x1_p_q <= x1_d;
    y0_p_q <= y0_d;
    y1_p_q <= y1_d;
    tx_p_q <= txe;
    ty_p_q <= tyn;
  end

  // row base stage
  logic [IndexBits:0]   prod0, prod1;
  item_t                item_a_q;
  logic [IndexBits-1:0] base0_q, base1_q;
  logic [ColBits-1:0]   x0_a_q, x1_a_q;
  logic [FracBits-1:0]  tx_a_q, ty_a_q;

  assign prod0 = (IndexBits+1)'(y0_p_q) * (IndexBits+1)'(cols_eff);
  assign prod1 = (IndexBits+1)'(y1_p_q) * (IndexBits+1)'(cols_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_a_q <= '0;
    end else begin
      item_a_q <= item_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base0_q <= prod0[IndexBits-1:0];
    base1_q <= prod1[IndexBits-1:0];
    x0_a_q  <= x0_p_q;
    x1_a_q  <= x1_p_q;
    tx_a_q  <= tx_p_q;
    ty_a_q  <= ty_p_q;
  end

  // grid access: four copies, each written by every load
  logic                  grid_we;
  logic [IndexBits-1:0]  addr [4];
  logic [HeightBits-1:0] hgt  [4];

  assign grid_we = item_a_q.valid && !item_a_q.action;
  assign addr[0] = base0_q + IndexBits'(x0_a_q);
  assign addr[1] = base0_q + IndexBits'(x1_a_q);
  assign addr[2] = base1_q + IndexBits'(x0_a_q);
  assign addr[3] = base1_q + IndexBits'(x1_a_q);

  for (genvar b = 0; b < 4; b++) begin : g_grid
    gbhs_ram #(
      .Width (HeightBits),
      .Depth (GridDepth)
    ) u_ram (
      .clk_i,
      .we_i    (grid_we),
      .waddr_i (item_a_q.idx),
      .wdata_i (item_a_q.hgt),
      .raddr_i (addr[b]),
      .rdata_o (hgt[b])
    );
  end

  item_t               item_r_q;
  logic [FracBits-1:0] tx_r_q, ty_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_r_q <= '0;
    end else begin
      item_r_q <= item_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_r_q <= tx_a_q;
    ty_r_q <= ty_a_q;
  end

  gbhs_blend u_blend (
    .clk_i,
    .rst_ni,
    .item_i         (item_r_q),
    .tx_i           (tx_r_q),
    .ty_i           (ty_r_q),
    .no_data_i      (no_data_q),
    .h00_i          (hgt[0]),
    .h10_i          (hgt[1]),
    .h01_i          (hgt[2]),
    .h11_i          (hgt[3]),
    .result_valid_o,
    .found_o,
    .height_o
  );

  `ASSERT_IMPLIES(a_fail_zero, clk_i, rst_ni, result_valid_o && !found_o, height_o == '0)
  `ASSERT_IMPLIES(a_result_from_sample, clk_i, rst_ni, result_valid_o, $past(start && action_i, Latency))
  `ASSERT_NEVER(a_load_no_result, clk_i, rst_ni, result_valid_o && $past(start && !action_i, Latency))

endmodule

/* test/height_sampler_checker.sv */
module height_sampler_checker import gbhs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    action_i,
  input  logic [IndexBits-1:0]    cell_index_i,
  input  logic [HeightBits-1:0]   cell_height_i,
  input  logic [CoordBits-1:0]    easting_i,
  input  logic [CoordBits-1:0]    northing_i,
  input  logic                    result_valid_o,
  input  logic                    found_o,
  input  logic [HeightBits-1:0]   height_o,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  output int unsigned             fail_count,
  output int unsigned             samples_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  found;
    logic [HeightBits-1:0] height;
  } sample_t;

  logic [CoordBits-1:0]    org_e, org_n;
  logic [CellSizeBits-1:0] csize;
  logic [DimBits-1:0]      ncols, nrows;
  logic [HeightBits-1:0]   nodata;
  logic [HeightBits-1:0]   heights [GridDepth];
  sample_t                 expected_samples [$];

  assign samples_pending = expected_samples.size();

  function automatic bit map_axis(input logic [31:0] pos, input logic [31:0] org,
                                  input int unsigned cnt, output int unsigned pos_cell,
                                  output int unsigned frac);
    longint unsigned d, q, r;
    if (pos < org) return 0;
    d = pos - org;
    q = d / csize;
    r = d % csize;
    if (q > cnt - 1) return 0;
    if (q == cnt - 1 && r != 0) return 0;
    pos_cell = 32'(q);
    frac = 32'((r << 16) / csize);
    return 1;
  endfunction

  function automatic bit read_cell(input int unsigned c, input int unsigned r,
                                   input int unsigned cols, output longint h);
    logic [15:0] a;
    a = 16'(r * cols + c);
    if (heights[a] == nodata) return 0;
    h = longint'(signed'(heights[a]));
    return 1;
  endfunction

  function automatic sample_t interpolate(input logic [31:0] e, input logic [31:0] n);
    sample_t s;
    int unsigned cols, rows, x0, y0, x1, y1, tx, ty;
    longint h00, h10, h01, h11, num;
    s = '0;
    cols = ncols > MaxColumns ? MaxColumns : ncols;
    rows = nrows > MaxRows ? MaxRows : nrows;
    if (cols == 0 || rows == 0 || csize == 0) return s;
    if (!map_axis(e, org_e, cols, x0, tx)) return s;
    if (!map_axis(n, org_n, rows, y0, ty)) return s;
    x1 = (x0 + 1 < cols) ? x0 + 1 : x0;
    y1 = (y0 + 1 < rows) ? y0 + 1 : y0;
    if (!read_cell(x0, y0, cols, h00) || !read_cell(x1, y0, cols, h10) ||
        !read_cell(x0, y1, cols, h01) || !read_cell(x1, y1, cols, h11)) return s;
    num = (h00 * (65536 - tx) + h10 * tx) * (65536 - ty) +
          (h01 * (65536 - tx) + h11 * tx) * ty;
    // round half up then drop 32 fraction bits
    num = (num + (64'sd1 <<< 31)) >>> 32;
    s.found = 1'b1;
    s.height = num[HeightBits-1:0];
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t want;
    if (!rst_ni) begin
      org_e <= '0; org_n <= '0; csize <= '0; ncols <= '0; nrows <= '0;
      nodata <= NoDataReset;
      fail_count <= 0;
      expected_samples.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgOriginEast:  org_e <= cfg_data_i;
          CfgOriginNorth: org_n <= cfg_data_i;
          CfgCellSize:    csize <= cfg_data_i[CellSizeBits-1:0];
          CfgGridColumns: ncols <= cfg_data_i[DimBits-1:0];
          CfgGridRows:    nrows <= cfg_data_i[DimBits-1:0];
          CfgNoData:      nodata <= cfg_data_i[HeightBits-1:0];
          default: ;
        endcase
      end
      if (result_valid_o) begin
        if (expected_samples.size() == 0) begin
          if (fail_count < 10) $display("unexpected result found=%0b height=%h",
                                        found_o, height_o);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_samples.pop_front();
          if (want.found !== found_o || want.height !== height_o) begin
            if (fail_count < 10)
              $display("result mismatch: expected found=%0b height=%h, got found=%0b height=%h",
                       want.found, want.height, found_o, height_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      // grid writes take effect immediately so a sample right after sees them
      if (start && !busy) begin
        if (!action_i) heights[cell_index_i] = cell_height_i;
        else expected_samples.push_back(interpolate(easting_i, northing_i));
      end
    end
  end
endmodule

/* test/tb_top.sv */
module tb_top import gbhs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0, rst_ni = 0;
  logic start = 0, action_i = 0;
  logic [IndexBits-1:0] cell_index_i = '0;
  logic [HeightBits-1:0] cell_height_i = '0;
  logic [CoordBits-1:0] easting_i = '0, northing_i = '0;
  logic cfg_valid_i = 0;
  logic [CfgIndexBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic busy, result_valid_o, found_o, cfg_ready_o;
  logic [HeightBits-1:0] height_o;
  int unsigned fail_count, samples_pending;
  int unsigned quiet_cycles = 0;
  bit calm = 0;

  // active configuration seen by the stimulus
  int unsigned cur_cols, cur_rows, cur_cs;
  logic [31:0] cur_oe, cur_on;
  logic [23:0] cur_nd;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  grid_bilinear_height_sampler_top dut (.*);
  height_sampler_checker u_checker (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic gap();
    int unsigned n;
    if (!calm && $urandom_range(3) == 0) begin
      n = $urandom_range(7, 1);
      start <= 0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic send(input logic act, input logic [15:0] idx, input logic [23:0] h,
                      input logic [31:0] e, input logic [31:0] n);
    start <= 1; action_i <= act; cell_index_i <= idx; cell_height_i <= h;
    easting_i <= e; northing_i <= n;
    do @(posedge clk_i); while (busy);
    gap();
  endtask

  task automatic drain();
    start <= 0;
    while (samples_pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] oe, input logic [31:0] on, input int unsigned cs,
                           input int unsigned cols, input int unsigned rows,
                           input logic [23:0] nd);
    drain();
    write_reg(CfgOriginEast, oe);
    write_reg(CfgOriginNorth, on);
    write_reg(CfgCellSize, cs);
    write_reg(CfgGridColumns, cols);
    write_reg(CfgGridRows, rows);
    write_reg(CfgNoData, {8'h00, nd});
    cfg_valid_i <= 0;
    cur_oe = oe; cur_on = on; cur_cs = cs; cur_cols = cols; cur_rows = rows; cur_nd = nd;
  endtask

  // fill every cell the sampler can address, a given percentage with the no-data marker
  task automatic fill_grid(input int unsigned nodata_pct);
    int unsigned c, r, cols, rows;
    logic [23:0] h;
    cols = cur_cols > MaxColumns ? MaxColumns : cur_cols;
    rows = cur_rows > MaxRows ? MaxRows : cur_rows;
    for (r = 0; r < rows; r++)
      for (c = 0; c < cols; c++) begin
        h = 24'($urandom());
        if ($urandom_range(99) < nodata_pct) h = cur_nd;
        else if (h == cur_nd) h = h ^ 24'h1;
        send(0, 16'(r * cols + c), h, 0, 0);
      end
  endtask

  function automatic logic [31:0] pick_coord(input logic [31:0] org, input int unsigned cnt);
    longint unsigned span;
    int unsigned k;
    if (cnt > MaxColumns) cnt = MaxColumns;
    span = longint'(cnt - 1) * cur_cs;
    k = $urandom_range(9);
    if (k == 0) return $urandom();
    if (k == 1) return org - $urandom_range(1, 50);
    if (k == 2) return 32'(org + span + $urandom_range(1, 3));
    if (k == 3) return 32'(org + span);
    return 32'(org + ({$urandom(), $urandom()} % (span + 1)));
  endfunction

  task automatic sample_burst(input int unsigned n);
    repeat (n) send(1, 16'($urandom()), 24'($urandom()), pick_coord(cur_oe, cur_cols),
                    pick_coord(cur_on, cur_rows));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // reset settings: invalid tile
    send(1, 16'hFFFF, 24'h7FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send(1, 0, 24'h800000, 0, 0);
    configure(32'h100, 32'h200, 24'h100, 4, 3, 24'h800000);
    fill_grid(0);
    send(0, 16'hFFFF, 24'h7FFFFF, 0, 0);
    send(1, 0, 0, 32'h100, 32'h200);
    send(1, 0, 0, 32'h100 + 3 * 256, 32'h200 + 2 * 256);
    send(1, 0, 0, 32'h100 + 3 * 256 + 1, 32'h200);
    send(1, 0, 0, 32'hFF, 32'h200);
    send(1, 0, 0, 32'h180, 32'h1FF);
    send(1, 0, 0, 32'h17F, 32'h2C1);
    send(0, 5, 24'h800000, 0, 0);
    send(1, 0, 0, 32'h180, 32'h280);
    send(0, 5, 24'h7FFFFF, 0, 0);
    send(0, 6, 24'h800001, 0, 0);
    send(1, 0, 0, 32'h280, 32'h280);
    // pause until every expected result is back
    drain();
    configure(0, 0, 0, 4, 4, 24'h000000);
    send(1, 0, 0, 0, 0);
    configure(0, 0, 24'hFFFFFF, 2, 2, 24'h7FFFFF);
    fill_grid(5);
    send(1, 0, 0, 32'hFFFFFF, 32'hFFFFFF);
    send(1, 0, 0, 32'hFFFFFFFF, 0);
    sample_burst(20);
    // oversized column count on a single row
    configure(32'hFFFFFF00, 32'hFFFFFF00, 1, 9'h1FF, 1, 24'h123456);
    fill_grid(0);
    sample_burst(40);
    configure(32'h12345, 32'h0, 24'h3, 9'd0, 5, 24'h800000);
    sample_burst(10);
    for (int p = 0; p < 6; p++) begin
      configure($urandom(), $urandom(), $urandom_range(4000, 1), $urandom_range(7, 2),
                $urandom_range(7, 1), 24'($urandom()));
      fill_grid(p * 4);
      sample_burst(20);
    end
    calm = 1;
    sample_burst(60);
    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/gbhs_pkg.sv
rtl/gbhs_ram.sv
rtl/gbhs_div_stage.sv
rtl/gbhs_blend.sv
rtl/grid_bilinear_height_sampler_top.sv
test/height_sampler_checker.sv
test/tb_top.sv
